// ===== hw/rtl/order_statistic_multiset_macros.svh =====
// Assertion macros for the order-statistic multiset.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef ORDER_STATISTIC_MULTISET_MACROS_SVH
`define ORDER_STATISTIC_MULTISET_MACROS_SVH

// same-cycle implication
`define OSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/osm_pkg.sv =====
// Shared types, codes and elaboration helpers for the order-statistic multiset.
// No dependencies; used by osm_cell, osm_tree and order_statistic_multiset.
package osm_pkg;

	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_VALUE_BITS = 32;
	localparam int RANK_BITS      = 16;
	localparam int REQ_BITS       = 2;
	localparam int STATUS_BITS    = 2;

	localparam int TREE_RADIX_BITS = 4;
	localparam int TREE_RADIX      = 1 << TREE_RADIX_BITS;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SELECT = 2'd2,
		REQ_RANK   = 2'd3
	} req_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic sel;
	} cell_ctl_t;

	// nodes on a level of the OR tree; level 0 is the leaves
	function automatic int tree_nodes(int n, int lvl);
		int span;
		span = 1 << (TREE_RADIX_BITS * lvl);
		return (n + span - 1) >> (TREE_RADIX_BITS * lvl);
	endfunction

	// registered levels until a single root remains
	function automatic int tree_levels(int n);
		int res;
		res = 8;
		for (int l = 8; l >= 1; l--) begin
			if (tree_nodes(n, l) <= 1) res = l;
		end
		return res;
	endfunction

	// start of a level in the flat node array; level 1 starts at zero
	function automatic int tree_offset(int n, int lvl);
		int sum;
		sum = 0;
		for (int k = 1; k < 16; k++) begin
			if (k < lvl) sum += tree_nodes(n, k);
		end
		return sum;
	endfunction

endpackage

// ===== hw/rtl/osm_cell.sv =====
// One slot of the sorted chain: holds a value and its valid bit, compares
// against the request key, shifts with its neighbors. Depends on osm_pkg.
module osm_cell #(
	parameter int VALUE_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  osm_pkg::cell_ctl_t           ctl,
	input  logic signed [VALUE_BITS-1:0] key,
	input  logic [osm_pkg::RANK_BITS-1:0] rank,
	input  logic signed [VALUE_BITS-1:0] left_value,
	input  logic                         left_lt,
	input  logic                         left_valid,
	input  logic signed [VALUE_BITS-1:0] right_value,
	input  logic                         right_valid,
	output logic signed [VALUE_BITS-1:0] value,
	output logic                         valid,
	output logic                         lt,
	output logic [VALUE_BITS:0]          leaf
);
	import osm_pkg::*;

	localparam logic [RANK_BITS:0]    POS1     = (RANK_BITS + 1)'(IDX + 1);
	localparam logic [VALUE_BITS-1:0] POS1_VAL = VALUE_BITS'(IDX + 1);

	logic signed [VALUE_BITS-1:0] value_q;
	logic                         valid_q;
	logic                         hit;
	logic [VALUE_BITS-1:0]        data;

	assign value = value_q;
	assign valid = valid_q;
	assign lt    = valid_q && (value_q < key);

	always_comb begin
		if (ctl.sel) begin
			hit  = valid_q && ({1'b0, rank} == POS1);
			data = value_q;
		end else begin
			hit  = valid_q && !lt && left_lt && (value_q == key);
			data = POS1_VAL;
		end
	end

	assign leaf = hit ? {1'b1, data} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !lt) begin
			valid_q <= left_valid;
		end else if (ctl.rem && !lt) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			value_q <= left_lt ? key : left_value;
		end else if (ctl.rem && !lt) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== hw/rtl/osm_tree.sv =====
// Registered 16-way OR tree that gathers the single hit word from the cells.
// Depends on osm_pkg for the level and offset helpers.
module osm_tree #(
	parameter int N = 1024,
	parameter int W = 33
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	import osm_pkg::*;

	localparam int LEVELS = tree_levels(N);
	localparam int TOTAL  = tree_offset(N, LEVELS + 1);

	logic [W-1:0] node_q [TOTAL];

	assign root = node_q[TOTAL-1];

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		localparam int NODES = tree_nodes(N, l);
		localparam int PREV  = tree_nodes(N, l - 1);
		localparam int OFF   = tree_offset(N, l);
		for (genvar j = 0; j < NODES; j++) begin : g_node
			localparam int LO  = j << TREE_RADIX_BITS;
			localparam int CNT = (PREV - LO < TREE_RADIX) ? (PREV - LO) : TREE_RADIX;
			logic [W-1:0] acc;
			if (l == 1) begin : g_leaf
				always_comb begin
					acc = '0;
					for (int c = 0; c < CNT; c++) begin
						acc |= leaf[LO + c];
					end
				end
			end else begin : g_inner
				localparam int POFF = tree_offset(N, l - 1);
				always_comb begin
					acc = '0;
					for (int c = 0; c < CNT; c++) begin
						acc |= node_q[POFF + LO + c];
					end
				end
			end
			always_ff @(posedge clk) begin
				node_q[OFF + j] <= acc;
			end
		end
	end

endmodule

// ===== hw/rtl/order_statistic_multiset.sv =====
// Order-statistic multiset: a sorted chain of CAPACITY cells answering insert,
// remove, select-by-rank and rank-of-value. Depends on osm_pkg, osm_cell,
// osm_tree and order_statistic_multiset_macros.svh.
//
// Each item passes through a register that takes the request, the LEVELS
// registered levels of the 16-way OR tree that collect the answer from the
// cells (LEVELS is ceil(log16(CAPACITY)), 3 levels at 1024 entries), and a
// final step that shifts the chain and loads the result. A new request is taken
// only once the previous item has committed. A result waiting on the output
// does not stop the next item from entering; it only holds back its commit.
// No clearing pass follows reset. Requests go in s_tuser, answers come with
// their status in m_tuser.
module order_statistic_multiset #(
	parameter int CAPACITY   = osm_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = osm_pkg::DEF_VALUE_BITS,
	localparam int IN_W  = ((VALUE_BITS + osm_pkg::RANK_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_W-1:0]                  s_tdata,  // item_value, rank_query
	input  logic [osm_pkg::REQ_BITS-1:0]     s_tuser,  // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,  // answer
	output logic [osm_pkg::STATUS_BITS-1:0]  m_tuser   // status
);
	import osm_pkg::*;
	`include "order_statistic_multiset_macros.svh"

	localparam int LEVELS   = tree_levels(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int WT_BITS  = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [WT_BITS-1:0]           wait_q;
	req_t                         req_q;
	logic signed [VALUE_BITS-1:0] key_q;
	logic [RANK_BITS-1:0]         rank_q;
	logic [CNT_BITS-1:0]          count_q;
	logic                         m_tvalid_q;
	logic [VALUE_BITS-1:0]        answer_q;
	status_t                      status_q;

	logic                         full;
	logic                         commit;
	logic                         found;
	cell_ctl_t                    ctl;
	logic [VALUE_BITS:0]          root;

	logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic                         cell_valid [CAPACITY];
	logic                         cell_lt    [CAPACITY];
	logic [VALUE_BITS:0]          leaf       [CAPACITY];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(answer_q);
	assign m_tuser  = status_q;

	assign full   = (count_q == CNT_BITS'(CAPACITY));
	assign found  = root[VALUE_BITS];
	assign commit = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign ctl.ins = commit && (req_q == REQ_INSERT) && !full;
	assign ctl.rem = commit && (req_q == REQ_REMOVE) && found;
	assign ctl.sel = (req_q == REQ_SELECT);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_BITS-1:0] lv;
		logic                         llt;
		logic                         lvd;
		logic signed [VALUE_BITS-1:0] rv;
		logic                         rvd;
		if (i == 0) begin : g_first
			assign lv  = key_q;
			assign llt = 1'b1;
			assign lvd = 1'b1;
		end else begin : g_left
			assign lv  = cell_value[i-1];
			assign llt = cell_lt[i-1];
			assign lvd = cell_valid[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv  = cell_value[i];
			assign rvd = 1'b0;
		end else begin : g_right
			assign rv  = cell_value[i+1];
			assign rvd = cell_valid[i+1];
		end
		osm_cell #(
			.VALUE_BITS(VALUE_BITS),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.rank       (rank_q),
			.left_value (lv),
			.left_lt    (llt),
			.left_valid (lvd),
			.right_value(rv),
			.right_valid(rvd),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.lt         (cell_lt[i]),
			.leaf       (leaf[i])
		);
	end

	osm_tree #(
		.N(CAPACITY),
		.W(VALUE_BITS + 1)
	) u_tree (
		.clk (clk),
		.leaf(leaf),
		.root(root)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= req_t'(s_tuser);
			key_q  <= s_tdata[VALUE_BITS-1:0];
			rank_q <= s_tdata[VALUE_BITS +: RANK_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wait_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			answer_q   <= '0;
			status_q   <= STAT_OK;
		end else begin
			if (m_tvalid_q && m_tready && !commit) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						wait_q  <= WT_BITS'(LEVELS);
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					wait_q <= wait_q - 1'b1;
					if (wait_q == WT_BITS'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
						unique case (req_q)
							REQ_INSERT: begin
								answer_q <= '0;
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									status_q <= STAT_OK;
									count_q  <= count_q + 1'b1;
								end
							end
							REQ_REMOVE: begin
								answer_q <= '0;
								if (found) begin
									status_q <= STAT_OK;
									count_q  <= count_q - 1'b1;
								end else begin
									status_q <= STAT_MISS;
								end
							end
							REQ_SELECT, REQ_RANK: begin
								if (found) begin
									answer_q <= root[VALUE_BITS-1:0];
									status_q <= STAT_OK;
								end else begin
									answer_q <= '1;
									status_q <= STAT_MISS;
								end
							end
							default: begin
								answer_q <= '1;
								status_q <= STAT_MISS;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`OSM_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_BITS'(CAPACITY), "count above capacity")
	`OSM_ASSERT_NOW(a_head_valid, 1'b1, cell_valid[0] == (count_q != '0), "head cell disagrees with count")
	`OSM_ASSERT_NEXT(a_count_hold, !commit, $stable(count_q), "count moved outside commit")
	`OSM_ASSERT_NEXT(a_insert_grow, ctl.ins, count_q == $past(count_q) + 1'b1, "insert did not grow count")

endmodule

// ===== bench/tb_order_statistic_multiset.sv =====
// Self-checking bench for order_statistic_multiset: insert, remove, select and rank
// requests checked against a sorted-queue predictor kept inside the bench.
// Depends on osm_pkg and the order_statistic_multiset RTL only.
`timescale 1ns / 100ps

module tb_order_statistic_multiset;
	import osm_pkg::*;

	localparam int CAPACITY    = osm_pkg::DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam int MIX_ITEMS   = 200;
	localparam int DRAIN_COUNT = 48;

	typedef struct {
		logic signed [31:0] answer;
		status_t            status;
	} result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;   // item_value, rank_query
	logic [REQ_BITS-1:0] s_tuser;   // req_type
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;   // answer
	logic [STATUS_BITS-1:0] m_tuser;   // status

	logic signed [31:0] held_values[$];
	result_t pending_results[$];
	logic signed [31:0] value_pool[8] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1,
		32'sd1, 32'sd42, -32'sd42, 32'sh7ffffffe};
	int mismatches;
	int cycle_count;
	bit no_idle;

	order_statistic_multiset u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int first_not_below(logic signed [31:0] value);
		int pos;
		pos = 0;
		while (pos < held_values.size() && held_values[pos] < value) pos++;
		return pos;
	endfunction

	function automatic void apply_request(req_t kind, logic signed [31:0] value,
			logic [15:0] rank);
		result_t res;
		int pos;
		res.answer = 32'sd0;
		res.status = STAT_OK;
		pos = first_not_below(value);
		case (kind)
			REQ_INSERT: begin
				if (held_values.size() >= CAPACITY) res.status = STAT_FULL;
				else held_values.insert(pos, value);
			end
			REQ_REMOVE: begin
				if (pos < held_values.size() && held_values[pos] == value)
					held_values.delete(pos);
				else res.status = STAT_MISS;
			end
			REQ_SELECT: begin
				if (rank >= 1 && rank <= held_values.size()) begin
					res.answer = held_values[rank - 1];
				end else begin
					res.answer = -32'sd1;
					res.status = STAT_MISS;
				end
			end
			default: begin
				if (pos < held_values.size() && held_values[pos] == value) begin
					res.answer = pos + 1;
				end else begin
					res.answer = -32'sd1;
					res.status = STAT_MISS;
				end
			end
		endcase
		pending_results.push_back(res);
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 45 && held_values.size() != 0)
			return held_values[$urandom_range(held_values.size() - 1)];
		if (r < 75) return value_pool[$urandom_range(7)];
		return $urandom;
	endfunction

	function automatic logic [15:0] pick_rank();
		if ($urandom_range(99) < 80) return 16'($urandom_range(held_values.size() + 1));
		return 16'($urandom_range(65535));
	endfunction

	task automatic send_request(input req_t kind, input logic signed [31:0] value,
			input logic [15:0] rank);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {rank, value};
		do @(posedge clk); while (!s_tready);
		apply_request(kind, value, rank);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_basic_ops();
		send_request(REQ_SELECT, $urandom, 16'd1);
		send_request(REQ_RANK, 32'sd0, 16'($urandom));
		send_request(REQ_REMOVE, 32'sd5, 16'($urandom));
		send_request(REQ_INSERT, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_INSERT, 32'sh80000000, 16'($urandom));
		send_request(REQ_INSERT, 32'sd0, 16'($urandom));
		send_request(REQ_INSERT, -32'sd1, 16'($urandom));
		send_request(REQ_INSERT, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_INSERT, 32'sd7, 16'($urandom));
		send_request(REQ_RANK, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_SELECT, $urandom, 16'd1);
		send_request(REQ_SELECT, $urandom, 16'd6);
		send_request(REQ_SELECT, $urandom, 16'd7);
		send_request(REQ_SELECT, $urandom, 16'd0);
		send_request(REQ_SELECT, $urandom, 16'hffff);
		send_request(REQ_RANK, -32'sd1, 16'($urandom));
		send_request(REQ_RANK, 32'sd8, 16'($urandom));
		send_request(REQ_REMOVE, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_RANK, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_REMOVE, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_REMOVE, 32'sh7fffffff, 16'($urandom));
		send_request(REQ_REMOVE, 32'sh80000000, 16'($urandom));
		send_request(REQ_REMOVE, 32'sd0, 16'($urandom));
		send_request(REQ_REMOVE, -32'sd1, 16'($urandom));
		send_request(REQ_REMOVE, 32'sd7, 16'($urandom));
		wait_drain();
	endtask

	task automatic test_full_store();
		logic signed [31:0] drain_order[$];
		logic signed [31:0] tmp;
		int j;
		while (held_values.size() < CAPACITY)
			send_request(REQ_INSERT, pick_value(), pick_rank());
		wait_drain();
		send_request(REQ_INSERT, pick_value(), pick_rank());
		send_request(REQ_INSERT, 32'sh7fffffff, pick_rank());
		send_request(REQ_SELECT, $urandom, 16'(CAPACITY));
		send_request(REQ_SELECT, $urandom, 16'(CAPACITY + 1));
		send_request(REQ_RANK, held_values[CAPACITY - 1], pick_rank());
		drain_order = held_values;
		for (int i = drain_order.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = drain_order[i];
			drain_order[i] = drain_order[j];
			drain_order[j] = tmp;
		end
		for (int i = 0; i < DRAIN_COUNT; i++)
			send_request(REQ_REMOVE, drain_order[i], pick_rank());
		wait_drain();
	endtask

	task automatic test_random_mix();
		int r;
		int insert_share;
		for (int n = 0; n < MIX_ITEMS; n++) begin
			no_idle = (n >= 60 && n < 140);
			insert_share = (held_values.size() < 24) ? 45 : 25;
			r = $urandom_range(99);
			if (r < insert_share) send_request(REQ_INSERT, pick_value(), pick_rank());
			else if (r < insert_share + 25) send_request(REQ_REMOVE, pick_value(), pick_rank());
			else if (r < insert_share + 45) send_request(REQ_SELECT, $urandom, pick_rank());
			else send_request(REQ_RANK, pick_value(), pick_rank());
		end
		no_idle = 1'b0;
		wait_drain();
	endtask

	always @(negedge clk) m_tready <= no_idle || ($urandom_range(99) >= 24);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: answer %0d status %0d",
						$signed(m_tdata), m_tuser);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata !== exp_res.answer) begin
					mismatches++;
					if (mismatches <= 10)
						$display("answer mismatch: expected %0d, got %0d",
							exp_res.answer, $signed(m_tdata));
				end
				if (m_tuser !== exp_res.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status mismatch: expected %0d, got %0d",
							exp_res.status, m_tuser);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_basic_ops();
		test_random_mix();
		test_full_store();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/osm_pkg.sv
hw/rtl/osm_cell.sv
hw/rtl/osm_tree.sv
hw/rtl/order_statistic_multiset.sv
bench/tb_order_statistic_multiset.sv
